// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the cache tag RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sacf_pkg.sv =====
// Types and constants shared by the cache tag controller, datapath and top level.
package sacf_pkg;

    localparam int ADDR_W      = 32;  // input address width
    localparam int EVT_W       = 20;  // evicted tag field width
    localparam int CNT_W       = 32;  // hit / miss counter width
    localparam int OUT_TDATA_W = 88;  // 87 result bits padded to 11 bytes

    // controller -> datapath
    typedef struct packed {
        logic clear;    // write one zero metadata row of the clearing pass
        logic capture;  // latch address, read tag and metadata rows
        logic commit;   // resolve lookup, write back, load result register
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;  // clearing pass at last row
        logic out_free;    // result register can take a new result
    } dp_stat_t;

endpackage

// ===== rtl/core/set_assoc_cache_tags_fifo.sv =====
// Top level of the set-associative cache tag model with FIFO replacement.
//
//  channel  dir  payload (tdata, lowest bit first)
//  -------  ---  ------------------------------------------------------------
//  s_       in   address[31:0]
//  m_       out  hit, way, evicted, evicted_tag[19:0], hit_count[31:0],
//                miss_count[31:0], one zero pad bit
//
// For each address, the capture cycle reads the set's tag row and metadata
// row from memory into registers; the lookup cycle then compares, writes
// back and loads the result register. The memory read is registered.
// After reset the metadata memory is swept clear row by row, and s_tready
// stays low meanwhile. A held result register stalls the lookup cycle until
// m_tready; the previous result can still be waiting while the next address
// is taken.

module set_assoc_cache_tags_fifo import sacf_pkg::*; #(
    parameter int BLOCK_BYTES = 64,   // power of two, 1..4096
    parameter int SET_COUNT   = 64,   // power of two, 1..4096
    parameter int WAYS        = 2,    // 1..16
    parameter int ADDR_BITS   = 32    // 16..64, address bits kept (at most 32)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [ADDR_W-1:0]      s_tdata,   // address[31:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // hit, way, evicted, evicted_tag[19:0],
                                              // hit_count[31:0], miss_count[31:0], pad
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // sequencing: clear pass, idle, lookup
    sacf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // tag / metadata memories, compare, victim pick, counters, result register
    sacf_dp #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .SET_COUNT   (SET_COUNT),
        .WAYS        (WAYS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/core/sacf_dp.sv =====
// Datapath: tag and metadata memories, way compare, FIFO victim select, counters.
`include "assert_macros.svh"

module sacf_dp import sacf_pkg::*; #(
    parameter int BLOCK_BYTES = 64,
    parameter int SET_COUNT   = 64,
    parameter int WAYS        = 2,
    parameter int ADDR_BITS   = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ctl_cmd_t               cmd,
    output dp_stat_t               stat,
    input  logic [ADDR_W-1:0]      s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int OFF_W   = $clog2(BLOCK_BYTES);
    localparam int SET_W   = $clog2(SET_COUNT);
    localparam int SET_IW  = (SET_W > 0) ? SET_W : 1;
    localparam int WAY_W   = $clog2(WAYS);
    localparam int WAY_IW  = (WAY_W > 0) ? WAY_W : 1;
    localparam int AW      = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int TAG_RAW = AW - OFF_W - SET_W;
    localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int ROW_W   = WAYS * TAG_W;
    localparam int META_W  = WAYS + WAY_IW;
    localparam logic [63:0] AMASK = (AW >= ADDR_W) ? 64'hFFFF_FFFF
                                                   : ((64'd1 << AW) - 64'd1);

    // address split
    logic [ADDR_W-1:0] addr_m;
    logic [ADDR_W-1:0] blk;
    logic [SET_IW-1:0] set_in;
    logic [TAG_W-1:0]  tag_in;

    assign addr_m = s_tdata & AMASK[ADDR_W-1:0];
    assign blk    = addr_m >> OFF_W;
    assign set_in = SET_IW'(blk) & SET_IW'(SET_COUNT - 1);
    assign tag_in = TAG_W'(addr_m >> (OFF_W + SET_W));

    // memories: one row per set; metadata = {fifo pointer, valid bits}
    logic [ROW_W-1:0]  tag_mem  [SET_COUNT];
    logic [META_W-1:0] meta_mem [SET_COUNT];

    logic [ROW_W-1:0]  tag_rd_reg;
    logic [META_W-1:0] meta_rd_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [SET_IW-1:0] set_reg;
    logic [SET_IW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            tag_rd_reg  <= tag_mem[set_in];
            meta_rd_reg <= meta_mem[set_in];
            tag_reg     <= tag_in;
            set_reg     <= set_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear) begin
            clr_addr_reg <= stat.clear_last ? '0 : SET_IW'(clr_addr_reg + 1'b1);
        end
    end

    assign stat.clear_last = (clr_addr_reg == SET_IW'(SET_COUNT - 1));

    // lookup resolve
    logic [WAYS-1:0]   valid;
    logic [WAY_IW-1:0] ptr;
    logic              hit_any;
    logic              inv_any;
    logic              evict;
    logic [WAY_IW-1:0] hit_idx;
    logic [WAY_IW-1:0] inv_idx;
    logic [WAY_IW-1:0] way_sel;
    logic [WAY_IW-1:0] ptr_next;
    logic [TAG_W-1:0]  old_tag;
    logic [ROW_W-1:0]  tag_row_next;
    logic [WAYS-1:0]   valid_next;

    assign valid = meta_rd_reg[WAYS-1:0];
    assign ptr   = meta_rd_reg[META_W-1:WAYS];

    always_comb begin
        hit_any = 1'b0;
        inv_any = 1'b0;
        hit_idx = '0;
        inv_idx = '0;
        // descending scan: lowest way wins
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (valid[i] && (tag_rd_reg[i*TAG_W +: TAG_W] == tag_reg)) begin
                hit_any = 1'b1;
                hit_idx = WAY_IW'(i);
            end
            if (!valid[i]) begin
                inv_any = 1'b1;
                inv_idx = WAY_IW'(i);
            end
        end
    end

    assign evict   = !hit_any && !inv_any;
    assign way_sel = hit_any ? hit_idx : (inv_any ? inv_idx : ptr);
    assign ptr_next = !evict ? ptr
                    : ((ptr == WAY_IW'(WAYS - 1)) ? '0 : WAY_IW'(ptr + 1'b1));

    always_comb begin
        old_tag      = '0;
        tag_row_next = tag_rd_reg;
        valid_next   = valid;
        for (int i = 0; i < WAYS; i++) begin
            if (evict && (WAY_IW'(i) == ptr)) begin
                old_tag = tag_rd_reg[i*TAG_W +: TAG_W];
            end
            if (WAY_IW'(i) == way_sel) begin
                tag_row_next[i*TAG_W +: TAG_W] = tag_reg;
                valid_next[i]                  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && !hit_any) begin
            tag_mem[set_reg] <= tag_row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            meta_mem[clr_addr_reg] <= '0;
        end else if (cmd.commit && !hit_any) begin
            meta_mem[set_reg] <= {ptr_next, valid_next};
        end
    end

    // saturating counters
    logic [CNT_W-1:0] hit_cnt_reg,  hit_cnt_next;
    logic [CNT_W-1:0] miss_cnt_reg, miss_cnt_next;

    always_comb begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (hit_any) begin
            if (hit_cnt_reg != '1) hit_cnt_next = hit_cnt_reg + 1'b1;
        end else begin
            if (miss_cnt_reg != '1) miss_cnt_next = miss_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end else if (cmd.commit) begin
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
        end
    end

    // result register
    logic [TAG_W+EVT_W-1:0] old_ext;
    logic                   m_valid_reg;
    logic                   o_hit_reg;
    logic                   o_way_reg;
    logic                   o_evict_reg;
    logic [EVT_W-1:0]       o_evtag_reg;

    assign old_ext = {{EVT_W{1'b0}}, old_tag};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            o_hit_reg   <= hit_any;
            o_way_reg   <= way_sel[0];
            o_evict_reg <= evict;
            o_evtag_reg <= old_ext[EVT_W-1:0];
        end
    end

    assign stat.out_free = !m_valid_reg || m_tready;
    assign m_tvalid      = m_valid_reg;
    assign m_tdata       = {1'b0, miss_cnt_reg, hit_cnt_reg, o_evtag_reg,
                            o_evict_reg, o_way_reg, o_hit_reg};

    `ASSERT_NEXT(a_commit_loads_out, aclk, aresetn, cmd.commit, m_valid_reg,
        "result register not loaded after commit")
    `ASSERT_IMPL(a_evict_full_set, aclk, aresetn, cmd.commit && evict, &valid,
        "eviction from a set with a free way")
    `ASSERT_NEXT(a_hit_counted, aclk, aresetn, cmd.commit && hit_any, hit_cnt_reg != '0,
        "hit counter zero after a hit")

endmodule

// ===== rtl/core/sacf_ctrl.sv =====
// Controller: clearing pass after reset, then capture / commit sequencing per address.
`include "assert_macros.svh"

module sacf_ctrl import sacf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output ctl_cmd_t cmd,
    input  dp_stat_t stat
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [1:0] state_reg, state_next;

    assign s_tready    = (state_reg == ST_IDLE);
    assign cmd.clear   = (state_reg == ST_CLEAR);
    assign cmd.capture = s_tready && s_tvalid;
    assign cmd.commit  = (state_reg == ST_LOOK) && stat.out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (stat.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_LOOK;
            end
            ST_LOOK: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    `ASSERT_NEXT(a_capture_to_look, aclk, aresetn, cmd.capture, state_reg == ST_LOOK,
        "no lookup after capture")
    `ASSERT_NEXT(a_commit_to_idle, aclk, aresetn, cmd.commit, state_reg == ST_IDLE,
        "not idle after commit")
    `ASSERT_NEXT(a_clear_done, aclk, aresetn, cmd.clear && stat.clear_last,
        state_reg == ST_IDLE, "clearing pass did not end")

endmodule
